// File: hdl/keyed_timeout_queue_unit_defines.svh
// assertion helpers for the checker file
`ifndef KEYED_TIMEOUT_QUEUE_UNIT_DEFINES_SVH
`define KEYED_TIMEOUT_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, ignored while reset is low
`define KTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while reset is low
`define KTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ktq_pkg.sv
package ktq_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IW          = $clog2(SLOTS);
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic [1:0] KIND_ARM    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_REARM     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_CANCELLED = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] timer_id;
        logic [30:0] timeout_ticks;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] expired_id;
        logic [2:0]  status;
        logic        last;
    } t_out;

    // search record that walks down the slot chain, one cell per cycle
    typedef struct packed {
        logic          act;
        logic [15:0]   key;
        logic          hit;
        logic [IW-1:0] hit_idx;
        logic          free;
        logic [IW-1:0] free_idx;
        logic          best;
        logic [IW-1:0] best_idx;
        logic [31:0]   best_age;
        logic [15:0]   best_key;
    } t_probe;

    // slot update broadcast to all cells
    typedef struct packed {
        logic          en;
        logic [IW-1:0] idx;
        logic          set_valid;
        logic          clr_valid;
        logic          wr_key;
        logic          wr_dl;
        logic [15:0]   key;
        logic [31:0]   deadline;
    } t_wr;

endpackage

// File: hdl/ktq_cell.sv
module ktq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [ktq_pkg::IW-1:0] i_idx,
    input  logic [31:0]           i_now,
    input  ktq_pkg::t_wr          i_wr,
    input  ktq_pkg::t_probe       i_probe,
    output ktq_pkg::t_probe       o_probe
);
    import ktq_pkg::*;

    logic        r_valid;
    logic [15:0] r_key;
    logic [31:0] r_dl;
    t_probe      r_probe;
    t_probe      n_probe;
    logic [31:0] w_age;
    logic        w_exp;
    logic        w_sel;

    assign w_age = i_now - r_dl;
    assign w_exp = r_valid && !w_age[31];
    assign w_sel = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_probe = i_probe;
        if (r_valid && (r_key == i_probe.key) && !i_probe.hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = i_idx;
        end
        if (!r_valid && !i_probe.free) begin
            n_probe.free     = 1'b1;
            n_probe.free_idx = i_idx;
        end
        // strictly older wins, so equal deadlines keep the lower slot
        if (w_exp && (!i_probe.best || (w_age > i_probe.best_age))) begin
            n_probe.best     = 1'b1;
            n_probe.best_idx = i_idx;
            n_probe.best_age = w_age;
            n_probe.best_key = r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
            if (w_sel && i_wr.set_valid) begin
                r_valid <= 1'b1;
            end else if (w_sel && i_wr.clr_valid) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel && i_wr.wr_key) begin
            r_key <= i_wr.key;
        end
        if (w_sel && i_wr.wr_dl) begin
            r_dl <= i_wr.deadline;
        end
    end

    assign o_probe = r_probe;

endmodule

// File: hdl/keyed_timeout_queue_unit.sv
// keyed timer table with a 32-bit tick counter
// input channel: i_in_valid / o_in_stall carry an arm, cancel or tick request
// output channel: o_out_valid / i_out_stall carry answers and expiries
// one request is worked on at a time; o_in_stall is high until it is done
// each request launches a search down a chain of SLOTS cells, one cell per cycle,
// and a decision follows once the search has left the last cell
// arm and cancel: one result, given at that decision once the output register is free
// tick: the counter advances at once, then one scan per expired timer
// (up to MAX_RESULTS), oldest deadline first, ties to the lowest slot;
// each expiry is held until the next decision hands it over, the final one marked last
// a tick with nothing expired gives no result and ends after one scan
// a request with opcode 3 is taken and dropped at once
// the output register holds a result while i_out_stall is high; work that has
// another result to hand over waits for it
// reset empties the table, zeroes the counter and drops any pending result
module keyed_timeout_queue_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ktq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ktq_pkg::t_out o_out_data
);
    import ktq_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]  r_state, n_state;
    logic        r_go, n_go;
    t_in         r_req, n_req;
    logic [31:0] r_dl, n_dl;
    logic [31:0] r_time, n_time;
    t_probe      r_res, n_res;
    logic [NW-1:0] r_nexp, n_nexp;
    logic        r_pend_v, n_pend_v;
    logic [15:0] r_pend_key, n_pend_key;
    logic        r_out_valid;
    t_out        r_out;

    logic        w_accept;
    logic        w_out_free;
    logic        w_emit;
    t_out        w_emit_data;
    t_wr         w_wr;
    t_probe      w_probe [SLOTS+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_probe[0]     = '0;
        w_probe[0].act = r_go;
        w_probe[0].key = r_req.timer_id;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        ktq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IW'(g)),
            .i_now   (r_time),
            .i_wr    (w_wr),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_go        = 1'b0;
        n_req       = r_req;
        n_dl        = r_dl;
        n_time      = r_time;
        n_res       = r_res;
        n_nexp      = r_nexp;
        n_pend_v    = r_pend_v;
        n_pend_key  = r_pend_key;
        w_wr        = '0;
        w_emit      = 1'b0;
        w_emit_data = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req = i_in_data;
                    n_dl  = r_time + {1'b0, i_in_data.timeout_ticks};
                    if (i_in_data.opcode == OP_TICK) begin
                        n_time = r_time + 32'd1;
                    end
                    if (i_in_data.opcode != OP_NONE) begin
                        n_state = S_SCAN;
                        n_go    = 1'b1;
                        n_nexp  = '0;
                    end
                end
            end
            S_SCAN: begin
                if (w_probe[SLOTS].act) begin
                    n_res   = w_probe[SLOTS];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                case (r_req.opcode)
                    OP_ARM: begin
                        if (w_out_free) begin
                            w_emit                 = 1'b1;
                            w_emit_data.kind       = KIND_ARM;
                            w_emit_data.expired_id = r_req.timer_id;
                            w_emit_data.last       = 1'b1;
                            w_wr.key               = r_req.timer_id;
                            w_wr.deadline          = r_dl;
                            if (r_res.hit) begin
                                w_wr.en            = 1'b1;
                                w_wr.idx           = r_res.hit_idx;
                                w_wr.wr_dl         = 1'b1;
                                w_emit_data.status = ST_REARM;
                            end else if (r_res.free) begin
                                w_wr.en            = 1'b1;
                                w_wr.idx           = r_res.free_idx;
                                w_wr.set_valid     = 1'b1;
                                w_wr.wr_key        = 1'b1;
                                w_wr.wr_dl         = 1'b1;
                                w_emit_data.status = ST_NEW;
                            end else begin
                                w_emit_data.status = ST_FULL;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_CANCEL: begin
                        if (w_out_free) begin
                            w_emit                 = 1'b1;
                            w_emit_data.kind       = KIND_CANCEL;
                            w_emit_data.expired_id = r_req.timer_id;
                            w_emit_data.last       = 1'b1;
                            if (r_res.hit) begin
                                w_wr.en            = 1'b1;
                                w_wr.idx           = r_res.hit_idx;
                                w_wr.clr_valid     = 1'b1;
                                w_emit_data.status = ST_CANCELLED;
                            end else begin
                                w_emit_data.status = ST_NOT_FOUND;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    OP_TICK: begin
                        if (r_res.best) begin
                            // the held expiry is not last, another one was found
                            if (!r_pend_v || w_out_free) begin
                                if (r_pend_v) begin
                                    w_emit                 = 1'b1;
                                    w_emit_data.kind       = KIND_EXPIRY;
                                    w_emit_data.expired_id = r_pend_key;
                                    w_emit_data.status     = ST_NEW;
                                    w_emit_data.last       = 1'b0;
                                end
                                w_wr.en        = 1'b1;
                                w_wr.idx       = r_res.best_idx;
                                w_wr.clr_valid = 1'b1;
                                n_pend_v       = 1'b1;
                                n_pend_key     = r_res.best_key;
                                n_nexp         = r_nexp + 1'b1;
                                if (r_nexp == NW'(MAX_RESULTS - 1)) begin
                                    n_state = S_FLUSH;
                                end else begin
                                    n_state = S_SCAN;
                                    n_go    = 1'b1;
                                end
                            end
                        end else if (r_pend_v) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit                 = 1'b1;
                    w_emit_data.kind       = KIND_EXPIRY;
                    w_emit_data.expired_id = r_pend_key;
                    w_emit_data.status     = ST_NEW;
                    w_emit_data.last       = 1'b1;
                    n_pend_v               = 1'b0;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_time      <= '0;
            r_nexp      <= '0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_go     <= n_go;
            r_time   <= n_time;
            r_nexp   <= n_nexp;
            r_pend_v <= n_pend_v;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (w_out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_dl       <= n_dl;
        r_res      <= n_res;
        r_pend_key <= n_pend_key;
        if (w_emit) begin
            r_out <= w_emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/ktq_checker.sv
`include "keyed_timeout_queue_unit_defines.svh"

module ktq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input ktq_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input ktq_pkg::t_out o_out_data
);
    import ktq_pkg::*;

    // a held result keeps its value until taken
    `KTQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "result changed while stalled")

    // a real request keeps the input side busy for its scan
    `KTQ_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall && (i_in_data.opcode != OP_NONE), o_in_stall, "request not followed by busy")

    // arm and cancel answers are always the only result of their request
    `KTQ_ASSERT_NOW(a_answer_last, o_out_valid && (o_out_data.kind != KIND_EXPIRY), o_out_data.last, "answer without last")

    // expiries carry status zero
    `KTQ_ASSERT_NOW(a_expiry_status, o_out_valid && (o_out_data.kind == KIND_EXPIRY), o_out_data.status == ST_NEW, "expiry with nonzero status")

    // arm answers use only the arm status codes
    `KTQ_ASSERT_NOW(a_arm_status, o_out_valid && (o_out_data.kind == KIND_ARM), (o_out_data.status == ST_NEW) || (o_out_data.status == ST_REARM) || (o_out_data.status == ST_FULL), "bad arm status")

endmodule

bind keyed_timeout_queue_unit ktq_checker u_ktq_checker (.*);
